// ===== src/sgct_pkg.sv =====
// Shared types and constants for the sorted glyph cache table.
`default_nettype none

package sgct_pkg;

    // Field widths of the item and result payloads.
    localparam int CODE_W     = 16;
    localparam int METRIC_W   = 32;
    localparam int SLOT_W     = 6;
    localparam int DIM_W      = 8;
    localparam int MAXE_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - METRIC_W - SLOT_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT  = 8'd1;
    localparam logic [MAXE_W-1:0]    MAX_ENTRIES_RST = 7'd64;
    localparam logic [DIM_W-1:0]     SIZE_LIMIT_RST  = 8'd16;

    // Function codes carried in the input tuser.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

    // Result status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

    // One table entry: metrics are x, y, width, height from the low byte up.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [METRIC_W-1:0] metrics;
        logic [CODE_W-1:0]   code;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                start;
        logic                probe_rd;
        logic                probe_upd;
        logic                place;
        logic                shift_rd;
        logic                shift_wr;
        logic                ovr_rd;
        logic                write;
        logic                set_res;
        logic [STATUS_W-1:0] res_status;
        logic                load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_fill;
        logic too_large;
        logic lo_lt_hi;
        logic code_eq;
        logic full;
        logic count_gt_lo;
        logic shift_more;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/sorted_glyph_cache_table.sv =====
// Glyph cache kept as a table sorted by character code.
//
// Input requests arrive on s_tvalid/s_tready: s_tuser selects lookup (0) or
// fill (1), s_tdata carries the code and the glyph metrics. One result per
// request leaves on m_tvalid/m_tready with the status in m_tuser.
// Configuration writes use cfg_valid/cfg_ready (always ready): index 0 sets
// max_entries, index 1 sets size_limit; other indexes are ignored. Write
// them only while no request is in flight.
// One request is worked at a time. Each binary-search probe runs a bound
// check, a memory read and a compare on the single memory port; a lookup
// makes at most clog2(entries+1) probes before its result is registered.
// A fill runs a lower-bound search, then a read and a write through the same
// port for each entry shifted up, then the place and write steps, with an
// extra read when a full table overwrites an entry; a rejected fill ends
// at the first bound check, with no search.
// The result register lets the next request be taken while the last result
// still waits; a stalled receiver holds the block before its next result.
// Reset empties the table at once (entry count zero, no clearing pass) and
// restores max_entries 64 and size_limit 16.
`default_nettype none

module sorted_glyph_cache_table
    import sgct_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata, low bit up: char_code[15:0], in_x[23:16], in_y[31:24],
    // in_width[39:32], in_height[47:40].
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: func.
    input  wire logic                  s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata, low bit up: slot[5:0], out_x[13:6], out_y[21:14],
    // out_width[29:22], out_height[37:30], zero pad[39:38].
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // m_tuser: status.
    output logic [STATUS_W-1:0]        m_tuser,
    // Configuration writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer for search, shift and write steps.
    sgct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Entry memory and registers.
    sgct_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== src/sgct_ctrl.sv =====
// Controller state machine that sequences search, shift and write steps.
`default_nettype none

module sgct_ctrl
    import sgct_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_CHECK     = 10'b00_0000_0010,
        S_PROBE_RD  = 10'b00_0000_0100,
        S_PROBE_CMP = 10'b00_0000_1000,
        S_PLACE     = 10'b00_0001_0000,
        S_SHIFT_RD  = 10'b00_0010_0000,
        S_SHIFT_WR  = 10'b00_0100_0000,
        S_OVR_RD    = 10'b00_1000_0000,
        S_WRITE     = 10'b01_0000_0000,
        S_FINISH    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_fill && stat.too_large)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_REJECT;
                    state_next     = S_FINISH;
                end
                else if (stat.lo_lt_hi)
                begin
                    state_next = S_PROBE_RD;
                end
                else if (!stat.is_fill)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_MISS;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PROBE_RD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PROBE_CMP;
            end
            S_PROBE_CMP:
            begin
                if (!stat.is_fill && stat.code_eq)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_HIT;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.probe_upd = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_PLACE:
            begin
                cmd.place = 1'b1;
                if (stat.full)
                begin
                    state_next = S_OVR_RD;
                end
                else if (stat.count_gt_lo)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = stat.shift_more ? S_SHIFT_RD : S_WRITE;
            end
            S_OVR_RD:
            begin
                cmd.ovr_rd = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write      = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_STORED;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sgct_dpath.sv =====
// Datapath: entry memory, search bounds, fill count, config and output registers.
`default_nettype none

module sgct_dpath
    import sgct_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    // Input item payload.
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    // Configuration writes.
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]        m_tuser
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > MAXE_W) ? CW : MAXE_W;

    // Entry memory, one port with registered read.
    entry_t mem [CAPACITY];
    entry_t rdata_reg;

    logic [CW-1:0]       count_reg;
    logic [MAXE_W-1:0]   max_entries_reg;
    logic [DIM_W-1:0]    size_limit_reg;
    logic                func_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [METRIC_W-1:0] metrics_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [CW-1:0]       ptr_reg;
    logic                full_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [CW-1:0]     mid;
    logic [CW-1:0]     ptr_m1;
    logic [IW-1:0]     raddr;
    logic              mem_re;
    logic              mem_we;
    entry_t            wdata;
    logic [SLOT_W-1:0] write_slot;
    logic [LW-1:0]     limit;
    logic [LW-1:0]     max_ext;
    logic              full;
    logic [DIM_W-1:0]  in_w;
    logic [DIM_W-1:0]  in_h;

    // Probe index: lookup rounds like the classic inclusive search,
    // fill finds the lower bound over the half-open range.
    always_comb
    begin
        if (func_reg == FUNC_FILL)
        begin
            mid = lo_reg + ((hi_reg - lo_reg) >> 1);
        end
        else
        begin
            mid = lo_reg + ((hi_reg - lo_reg - CW'(1)) >> 1);
        end
    end

    assign ptr_m1 = ptr_reg - CW'(1);

    // Table limit: zero acts as one, and it never exceeds the capacity.
    assign max_ext = LW'(max_entries_reg);
    always_comb
    begin
        if (max_entries_reg == '0)
        begin
            limit = LW'(1);
        end
        else if (max_ext > LW'(CAPACITY))
        begin
            limit = LW'(CAPACITY);
        end
        else
        begin
            limit = max_ext;
        end
    end
    assign full = (LW'(count_reg) >= limit);

    assign in_w = metrics_reg[23:16];
    assign in_h = metrics_reg[31:24];

    // Status toward the controller.
    always_comb
    begin
        stat.is_fill     = (func_reg == FUNC_FILL);
        stat.too_large   = (in_w > size_limit_reg) || (in_h > size_limit_reg);
        stat.lo_lt_hi    = (lo_reg < hi_reg);
        stat.code_eq     = (rdata_reg.code == code_reg);
        stat.full        = full;
        stat.count_gt_lo = (count_reg > lo_reg);
        stat.shift_more  = (ptr_reg > (lo_reg + CW'(1)));
        stat.out_free    = !out_valid_reg || m_tready;
    end

    // Memory address and write data selection.
    always_comb
    begin
        mem_re = cmd.probe_rd || cmd.shift_rd || cmd.ovr_rd;
        mem_we = cmd.shift_wr || cmd.write;
        if (cmd.probe_rd)
        begin
            raddr = mid[IW-1:0];
        end
        else if (cmd.shift_rd)
        begin
            raddr = ptr_m1[IW-1:0];
        end
        else
        begin
            raddr = ptr_reg[IW-1:0];
        end
        write_slot = full_reg ? rdata_reg.slot : SLOT_W'(count_reg);
        if (cmd.shift_wr)
        begin
            wdata = rdata_reg;
        end
        else
        begin
            wdata.slot    = write_slot;
            wdata.metrics = metrics_reg;
            wdata.code    = code_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg[IW-1:0]] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Item, search bound and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg    <= s_tuser;
            code_reg    <= s_tdata[CODE_W-1:0];
            metrics_reg <= s_tdata[IN_DATA_W-1:CODE_W];
            lo_reg      <= '0;
            hi_reg      <= count_reg;
        end
        if (cmd.probe_upd)
        begin
            if (rdata_reg.code < code_reg)
            begin
                lo_reg <= mid + CW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.place)
        begin
            full_reg <= full;
            if (!full)
            begin
                ptr_reg <= count_reg;
            end
            else if (lo_reg == count_reg)
            begin
                ptr_reg <= count_reg - CW'(1);
            end
            else
            begin
                ptr_reg <= lo_reg;
            end
        end
        if (cmd.shift_wr)
        begin
            ptr_reg <= ptr_m1;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
        end
        if (cmd.write)
        begin
            res_slot_reg <= write_slot;
        end
        else if (cmd.set_res)
        begin
            res_slot_reg <= (cmd.res_status == ST_HIT) ? rdata_reg.slot : '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            case (res_status_reg)
                ST_HIT:
                begin
                    out_data_reg <= {{OUT_PAD_W{1'b0}}, rdata_reg.metrics, res_slot_reg};
                end
                ST_STORED:
                begin
                    out_data_reg <= {{OUT_PAD_W{1'b0}}, metrics_reg, res_slot_reg};
                end
                default:
                begin
                    out_data_reg <= '0;
                end
            endcase
        end
    end

    // Fill count, configuration and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            max_entries_reg <= MAX_ENTRIES_RST;
            size_limit_reg  <= SIZE_LIMIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.write && !full_reg)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[MAXE_W-1:0];
                    CFG_SIZE_LIMIT:  size_limit_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== bench/sorted_glyph_cache_table_tb.sv =====
// Self-checking testbench for the sorted glyph cache table: directed and random requests.
`default_nettype none

module sorted_glyph_cache_table_tb;
    import sgct_pkg::*;

    localparam int DEPTH         = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 300;
    localparam int IDLE_PERCENT  = 19;
    localparam int REPORT_LIMIT  = 10;

    // Expected result of one request, fields as they leave the block.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [DIM_W-1:0]    x;
        logic [DIM_W-1:0]    y;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } glyph_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = FUNC_LOOKUP;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the glyph table and its registers.
    logic [CODE_W-1:0]   cache_codes   [DEPTH];
    logic [METRIC_W-1:0] cache_metrics [DEPTH];
    logic [SLOT_W-1:0]   cache_slots   [DEPTH];
    int                  cache_count      = 0;
    logic [MAXE_W-1:0]   cfg_max_entries  = MAX_ENTRIES_RST;
    logic [DIM_W-1:0]    cfg_size_limit   = SIZE_LIMIT_RST;

    glyph_result_t pending_results [$];
    int            mismatch_count = 0;
    logic          steady_flow    = 1'b0;

    sorted_glyph_cache_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Works out the answer to one request and updates the shadow table.
    function automatic glyph_result_t cache_response(input logic func,
                                                     input logic [CODE_W-1:0] code,
                                                     input logic [DIM_W-1:0] x,
                                                     input logic [DIM_W-1:0] y,
                                                     input logic [DIM_W-1:0] w,
                                                     input logic [DIM_W-1:0] h);
        glyph_result_t r;
        int lo;
        int hi;
        int mid;
        int pos;
        int usable;
        r = '0;
        if (func == FUNC_LOOKUP)
        begin
            // Binary search over the entries in use.
            r.status = ST_MISS;
            lo = 0;
            hi = cache_count - 1;
            while (lo <= hi)
            begin
                mid = lo + ((hi - lo) >>> 1);
                if (cache_codes[mid] == code)
                begin
                    r.status = ST_HIT;
                    r.slot   = cache_slots[mid];
                    {r.height, r.width, r.y, r.x} = cache_metrics[mid];
                    return r;
                end
                if (cache_codes[mid] < code)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            return r;
        end
        if (w > cfg_size_limit || h > cfg_size_limit)
        begin
            r.status = ST_REJECT;
            return r;
        end
        // Insert before the first entry whose code is not smaller.
        pos = 0;
        while (pos < cache_count && cache_codes[pos] < code)
            pos++;
        usable = (cfg_max_entries == 0) ? 1 :
                 (cfg_max_entries > DEPTH) ? DEPTH : int'(cfg_max_entries);
        if (cache_count < usable)
        begin
            for (int i = cache_count; i > pos; i--)
            begin
                cache_codes[i]   = cache_codes[i - 1];
                cache_metrics[i] = cache_metrics[i - 1];
                cache_slots[i]   = cache_slots[i - 1];
            end
            cache_slots[pos] = SLOT_W'(cache_count);
            cache_count++;
        end
        else if (pos == cache_count)
        begin
            // A full table with no larger code overwrites its last entry.
            pos = cache_count - 1;
        end
        cache_codes[pos]   = code;
        cache_metrics[pos] = {h, w, y, x};
        r.status = ST_STORED;
        r.slot   = cache_slots[pos];
        r.x      = x;
        r.y      = y;
        r.width  = w;
        r.height = h;
        return r;
    endfunction

    // Sends one request and records its expected result on acceptance.
    task automatic send_request(input logic func, input logic [CODE_W-1:0] code,
                                input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
                                input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {h, w, y, x, code};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(cache_response(func, code, x, y, w, h));
    endtask

    // Stops the request stream and waits for every result to come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one configuration register once the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_MAX_ENTRIES)
            cfg_max_entries = value[MAXE_W-1:0];
        else if (index == CFG_SIZE_LIMIT)
            cfg_size_limit = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Empty-table lookup, fills at the field extremes and the reset size limit, more lookups.
    task automatic test_extremes();
        send_request(FUNC_LOOKUP, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(FUNC_FILL,   16'h8000, 8'h7F, 8'h80, 8'd16, 8'd16);
        send_request(FUNC_FILL,   16'h0000, 8'h80, 8'h7F, 8'd0,  8'd0);
        send_request(FUNC_FILL,   16'hFFFF, 8'hA5, 8'h5A, 8'd5,  8'd3);
        send_request(FUNC_FILL,   16'h2222, 8'h01, 8'h02, 8'd17, 8'd0);
        send_request(FUNC_FILL,   16'h2222, 8'h01, 8'h02, 8'd0,  8'd17);
        send_request(FUNC_FILL,   16'h3333, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // A second fill of the same code lands in front of the first.
        send_request(FUNC_FILL,   16'h8000, 8'h11, 8'hEE, 8'd9,  8'd10);
        // Metric fields of a lookup carry junk and must be ignored.
        send_request(FUNC_LOOKUP, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(FUNC_LOOKUP, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(FUNC_LOOKUP, 16'h8000, 8'h55, 8'hAA, 8'h55, 8'hAA);
        send_request(FUNC_LOOKUP, 16'h7FFF, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Size limit at zero and at its top value.
    task automatic test_size_limit();
        write_register(CFG_SIZE_LIMIT, 8'd0);
        send_request(FUNC_FILL, 16'h0100, 8'h10, 8'h20, 8'd0, 8'd0);
        send_request(FUNC_FILL, 16'h0101, 8'h10, 8'h20, 8'd1, 8'd0);
        send_request(FUNC_FILL, 16'h0102, 8'h10, 8'h20, 8'd0, 8'd1);
        write_register(CFG_SIZE_LIMIT, 8'd255);
        send_request(FUNC_FILL, 16'hFFFE, 8'h80, 8'h80, 8'd255, 8'd255);
        send_request(FUNC_LOOKUP, 16'hFFFE, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Entry limit clamped to one while the table holds more: fills overwrite.
    task automatic test_entry_limit();
        write_register(CFG_MAX_ENTRIES, 8'd0);
        send_request(FUNC_FILL, 16'h4000, 8'h03, 8'h04, 8'd2, 8'd2);
        send_request(FUNC_LOOKUP, 16'h4000, 8'h00, 8'h00, 8'h00, 8'h00);
        // Writes to indexes outside the register list change nothing.
        write_register(8'd2, 8'd64);
        write_register(8'hFF, 8'hFF);
        send_request(FUNC_FILL, 16'h0001, 8'h7E, 8'h81, 8'd4, 8'd6);
        send_request(FUNC_LOOKUP, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Random mix of lookups and fills under one register setting.
    task automatic test_random_traffic(input int items, input logic [7:0] max_entries_val,
                                       input logic [7:0] size_val, input int code_span,
                                       input logic steady);
        logic              func;
        logic [CODE_W-1:0] code;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        int                pick;
        write_register(CFG_MAX_ENTRIES, max_entries_val);
        write_register(CFG_SIZE_LIMIT, size_val);
        steady_flow <= steady;
        repeat (items)
        begin
            func = ($urandom_range(0, 99) < 45) ? FUNC_FILL : FUNC_LOOKUP;
            pick = $urandom_range(0, 99);
            // Codes already cached, codes below the code span, and some anywhere.
            if (cache_count > 0 && pick < 40)
                code = cache_codes[$urandom_range(0, cache_count - 1)];
            else if (pick < 85)
                code = CODE_W'($urandom_range(0, code_span - 1));
            else
                code = CODE_W'($urandom);
            if ($urandom_range(0, 99) < 85)
            begin
                w = DIM_W'($urandom_range(0, cfg_size_limit));
                h = DIM_W'($urandom_range(0, cfg_size_limit));
            end
            else
            begin
                w = DIM_W'($urandom);
                h = DIM_W'($urandom);
            end
            send_request(func, code, DIM_W'($urandom), DIM_W'($urandom), w, h);
        end
        wait_idle();
        steady_flow <= 1'b0;
    endtask

    // Result checker; also drives the receiver's ready with random stalls.
    always @(posedge clk)
    begin
        glyph_result_t expected;
        glyph_result_t actual;
        if (rst_n && m_tvalid && m_tready)
        begin
            actual.status = m_tuser;
            actual.slot   = m_tdata[5:0];
            actual.x      = m_tdata[13:6];
            actual.y      = m_tdata[21:14];
            actual.width  = m_tdata[29:22];
            actual.height = m_tdata[37:30];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result: status %0d slot %0d", actual.status,
                             actual.slot);
            end
            else
            begin
                expected = pending_results.pop_front();
                if (actual.status !== expected.status || actual.slot !== expected.slot ||
                    actual.x !== expected.x || actual.y !== expected.y ||
                    actual.width !== expected.width || actual.height !== expected.height)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("Mismatch: expected status %0d slot %0d x %0d y %0d w %0d h %0d",
                                 expected.status, expected.slot, $signed(expected.x),
                                 $signed(expected.y), expected.width, expected.height);
                        $display("          got status %0d slot %0d x %0d y %0d w %0d h %0d",
                                 actual.status, actual.slot, $signed(actual.x),
                                 $signed(actual.y), actual.width, actual.height);
                    end
                end
            end
        end
        m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_size_limit();
        test_entry_limit();
        test_random_traffic(150, 8'd10,  8'd16,  64,    1'b0);
        test_random_traffic(200, 8'd33,  8'd40,  4096,  1'b0);
        test_random_traffic(150, 8'd64,  8'd255, 65536, 1'b1);
        test_random_traffic(250, 8'hFF,  8'd16,  1024,  1'b0);
        test_random_traffic(100, 8'd228, 8'd1,   256,   1'b0);
        test_random_traffic(100, 8'd100, 8'd200, 65536, 1'b0);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run time limit.
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
